// ===== rtl/sfs_pkg.sv =====
// Shared types, constants and helpers for the sprite frame sequencer.
// Used by the channel interfaces, the rectangle unit, the top level and the checker.
// No dependencies.
package sfs_pkg;

    localparam int FRAME_BITS = 8;
    localparam int TIME_BITS  = 16;
    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 12;

    // Frame numbers carry one extra bit so that "end plus one" fits.
    localparam int FRAME_W = FRAME_BITS + 1;
    localparam int ACCUM_W = TIME_BITS + 1;

    // Product widths: remainder times width, quotient times height.
    localparam int LEFT_W = FRAME_BITS + DIM_BITS;
    localparam int TOP_W  = FRAME_W + DIM_BITS;
    localparam int SUM_W  = TOP_W + 1;
    localparam int SAT_W  = (SUM_W > COORD_BITS) ? SUM_W : COORD_BITS;

    // Step counter for the serial divider and multiplier.
    localparam int CNT_W = $clog2(FRAME_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (TIME_BITS > DIM_BITS) ? TIME_BITS : DIM_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRAME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_FRAME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd6;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_PLAY      = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_PAUSE     = 3'd3,
        CMD_SET_FRAME = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } rect_t;

    // Clamp a full precision coordinate to the largest value of the output field.
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [SAT_W-1:0] v);
        logic [COORD_BITS-1:0] lim;
        lim = '1;
        if (v > SAT_W'(lim))
            return lim;
        else
            return v[COORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/sfs_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on sfs_pkg for the field widths.
interface sfs_item_if import sfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            cmd;
    logic [TIME_BITS-1:0]  elapsed_ticks;
    logic [FRAME_BITS-1:0] frame_value;

    modport source (output valid, cmd, elapsed_ticks, frame_value, input ready);
    modport sink   (input valid, cmd, elapsed_ticks, frame_value, output ready);
endinterface

interface sfs_result_if import sfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FRAME_W-1:0]    frame_now;
    logic                  playing;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;

    modport source (output valid, frame_now, playing, rect_left, rect_top, rect_right,
                    rect_bottom, input ready);
    modport sink   (input valid, frame_now, playing, rect_left, rect_top, rect_right,
                    rect_bottom, output ready);
endinterface

// ===== rtl/sfs_rect.sv =====
// Source rectangle unit: bit-serial divide of the frame index by the column count,
// then bit-serial multiply of remainder and quotient by the frame size.
// Depends on sfs_pkg.
module sfs_rect import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAME_W-1:0]    frame,
    input  logic [FRAME_BITS-1:0] cols,
    input  logic [DIM_BITS-1:0]   width,
    input  logic [DIM_BITS-1:0]   height,
    output logic                  done,
    output rect_t                 rect
);

    typedef enum logic [1:0] {P_IDLE, P_DIV, P_MUL, P_FIN} phase_t;

    phase_t                phase_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [FRAME_BITS-1:0] rem_reg;
    logic [FRAME_W-1:0]    quo_reg;
    logic [LEFT_W-1:0]     acc_l_reg, mc_l_reg;
    logic [TOP_W-1:0]      acc_t_reg, mc_t_reg;
    logic [FRAME_BITS-1:0] mp_l_reg;
    logic [FRAME_W-1:0]    mp_t_reg;
    rect_t                 rect_reg;

    logic [FRAME_W-1:0]    idx;
    logic [FRAME_BITS-1:0] cols_eff;
    logic [FRAME_W-1:0]    trial;
    logic                  fits;
    logic [FRAME_W-1:0]    diff;
    logic [FRAME_BITS-1:0] rem_next;
    logic [FRAME_W-1:0]    quo_next;

    // Frame zero is treated as frame one, and zero columns as one column.
    assign idx      = (frame == '0) ? '0 : frame - 1'b1;
    assign cols_eff = (cols == '0) ? FRAME_BITS'(1) : cols;

    // One restoring division step: bring down the next dividend bit.
    assign trial    = {rem_reg, quo_reg[FRAME_W-1]};
    assign fits     = trial >= {1'b0, cols_eff};
    assign diff     = trial - {1'b0, cols_eff};
    assign rem_next = fits ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
    assign quo_next = {quo_reg[FRAME_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            acc_l_reg <= '0;
            acc_t_reg <= '0;
            mc_l_reg  <= '0;
            mc_t_reg  <= '0;
            mp_l_reg  <= '0;
            mp_t_reg  <= '0;
            rect_reg  <= '0;
        end
        else
        begin
            done_reg <= (phase_reg == P_FIN);
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= idx;
                        cnt_reg   <= CNT_W'(FRAME_W - 1);
                        phase_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    if (cnt_reg == '0)
                    begin
                        mp_l_reg  <= rem_next;
                        mp_t_reg  <= quo_next;
                        mc_l_reg  <= LEFT_W'(width);
                        mc_t_reg  <= TOP_W'(height);
                        acc_l_reg <= '0;
                        acc_t_reg <= '0;
                        cnt_reg   <= CNT_W'(FRAME_W - 1);
                        phase_reg <= P_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                P_MUL:
                begin
                    if (mp_l_reg[0])
                        acc_l_reg <= acc_l_reg + mc_l_reg;
                    if (mp_t_reg[0])
                        acc_t_reg <= acc_t_reg + mc_t_reg;
                    mc_l_reg <= {mc_l_reg[LEFT_W-2:0], 1'b0};
                    mc_t_reg <= {mc_t_reg[TOP_W-2:0], 1'b0};
                    mp_l_reg <= {1'b0, mp_l_reg[FRAME_BITS-1:1]};
                    mp_t_reg <= {1'b0, mp_t_reg[FRAME_W-1:1]};
                    if (cnt_reg == '0)
                        phase_reg <= P_FIN;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                P_FIN:
                begin
                    rect_reg.left   <= sat_coord(SAT_W'(acc_l_reg));
                    rect_reg.top    <= sat_coord(SAT_W'(acc_t_reg));
                    rect_reg.right  <= sat_coord(SAT_W'(acc_l_reg) + SAT_W'(width));
                    rect_reg.bottom <= sat_coord(SAT_W'(acc_t_reg) + SAT_W'(height));
                    phase_reg       <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rect = rect_reg;

endmodule

// ===== rtl/sprite_frame_sequencer.sv =====
// Sprite frame sequencer top level; uses sfs_pkg, sfs_if and sfs_rect.
// A command transfer starts sfs_rect. The result is loaded into the output register
// once the rectangle is done and that register is free; only then is a new command
// taken, after the bit-serial divide and multiply in sfs_rect, each FRAME_BITS+1 steps.
// Reset (rst_n, asynchronous, active low) stops playback, clears the time accumulator,
// sets the frame to 1 and loads the register defaults; no clearing pass is needed.
module sprite_frame_sequencer import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfs_item_if.sink              item,
    sfs_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_HOLD} state_t;

    // Configuration registers.
    logic [TIME_BITS-1:0]  max_frame_time_reg;
    logic [FRAME_BITS-1:0] start_frame_reg;
    logic [FRAME_BITS-1:0] end_frame_reg;
    logic                  loop_enable_reg;
    logic [FRAME_BITS-1:0] sheet_columns_reg;
    logic [DIM_BITS-1:0]   frame_width_reg;
    logic [DIM_BITS-1:0]   frame_height_reg;

    // Animation state.
    logic                  play_flag_reg, play_flag_next;
    logic [ACCUM_W-1:0]    time_accum_reg, time_accum_next;
    logic [FRAME_W-1:0]    current_frame_reg, current_frame_next;

    // Control and output register.
    state_t                state_reg;
    logic                  result_valid_reg;
    logic [FRAME_W-1:0]    frame_now_reg;
    logic                  playing_reg;
    rect_t                 rect_out_reg;

    logic                  item_xfer;
    logic                  out_free;
    logic                  load_out;
    logic [ACCUM_W:0]      accum_sum;
    logic [ACCUM_W-1:0]    accum_sat;
    logic [FRAME_W-1:0]    frame_inc;
    logic                  rect_done;
    rect_t                 rect_res;

    // Commands are taken only between calculations. A finished result can still be
    // waiting in the output register while the next command is taken.
    assign item.ready = (state_reg == S_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign out_free   = !result_valid_reg || result.ready;

    // The output register loads when a rectangle is ready, either fresh from the
    // rectangle unit or held back in S_HOLD, and the register is free.
    assign load_out   = out_free && (((state_reg == S_CALC) && rect_done)
                                     || (state_reg == S_HOLD));

    // Configuration writes. Values are truncated to the register width, and an
    // index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_time_reg <= TIME_BITS'(1);
            start_frame_reg    <= FRAME_BITS'(1);
            end_frame_reg      <= FRAME_BITS'(1);
            loop_enable_reg    <= 1'b0;
            sheet_columns_reg  <= FRAME_BITS'(1);
            frame_width_reg    <= DIM_BITS'(1);
            frame_height_reg   <= DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_FRAME_TIME: max_frame_time_reg <= cfg_data[TIME_BITS-1:0];
                REG_START_FRAME:    start_frame_reg    <= cfg_data[FRAME_BITS-1:0];
                REG_END_FRAME:      end_frame_reg      <= cfg_data[FRAME_BITS-1:0];
                REG_LOOP_ENABLE:    loop_enable_reg    <= cfg_data[0];
                REG_SHEET_COLUMNS:  sheet_columns_reg  <= cfg_data[FRAME_BITS-1:0];
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[DIM_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // The accumulator saturates instead of wrapping, and the frame counter holds at
    // its top value before the end-of-range test.
    assign accum_sum = {1'b0, time_accum_reg} + (ACCUM_W + 1)'(item.elapsed_ticks);
    assign accum_sat = accum_sum[ACCUM_W] ? '1 : accum_sum[ACCUM_W-1:0];
    assign frame_inc = (&current_frame_reg) ? current_frame_reg
                                            : current_frame_reg + 1'b1;

    // Command decode. The new state is applied at the command transfer, and the
    // rectangle unit starts on the new frame number in the same cycle.
    always_comb
    begin
        play_flag_next     = play_flag_reg;
        time_accum_next    = time_accum_reg;
        current_frame_next = current_frame_reg;
        if (item_xfer)
        begin
            case (item.cmd)
                CMD_TICK:
                begin
                    if (play_flag_reg)
                    begin
                        if (accum_sat >= ACCUM_W'(max_frame_time_reg))
                        begin
                            time_accum_next    = '0;
                            current_frame_next = frame_inc;
                            if (frame_inc > FRAME_W'(end_frame_reg))
                            begin
                                // Past the end: wrap when looping, otherwise stop and
                                // leave the frame one beyond the end.
                                if (loop_enable_reg)
                                    current_frame_next = FRAME_W'(start_frame_reg);
                                else
                                    play_flag_next = 1'b0;
                            end
                        end
                        else
                        begin
                            time_accum_next = accum_sat;
                        end
                    end
                end
                CMD_PLAY:
                begin
                    play_flag_next = 1'b1;
                end
                CMD_STOP:
                begin
                    play_flag_next     = 1'b0;
                    time_accum_next    = '0;
                    current_frame_next = FRAME_W'(1);
                end
                CMD_PAUSE:
                begin
                    play_flag_next = 1'b0;
                end
                CMD_SET_FRAME:
                begin
                    current_frame_next = FRAME_W'(item.frame_value);
                    time_accum_next    = '0;
                end
                default:
                begin
                    // Unused codes change nothing but still produce a result.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_flag_reg     <= 1'b0;
            time_accum_reg    <= '0;
            current_frame_reg <= FRAME_W'(1);
        end
        else
        begin
            play_flag_reg     <= play_flag_next;
            time_accum_reg    <= time_accum_next;
            current_frame_reg <= current_frame_next;
        end
    end

    sfs_rect u_rect
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (item_xfer),
        .frame  (current_frame_next),
        .cols   (sheet_columns_reg),
        .width  (frame_width_reg),
        .height (frame_height_reg),
        .done   (rect_done),
        .rect   (rect_res)
    );

    // Sequencer and output register. When the rectangle is ready but the previous
    // result has not been taken yet, the sequencer waits in S_HOLD; the rectangle
    // unit keeps its result stable because no new command can start it meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            frame_now_reg    <= '0;
            playing_reg      <= 1'b0;
            rect_out_reg     <= '0;
        end
        else
        begin
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
                frame_now_reg    <= current_frame_reg;
                playing_reg      <= play_flag_reg;
                rect_out_reg     <= rect_res;
            end
            else if (result_valid_reg && result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_xfer)
                        state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (rect_done)
                        state_reg <= out_free ? S_IDLE : S_HOLD;
                end
                S_HOLD:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.frame_now   = frame_now_reg;
    assign result.playing     = playing_reg;
    assign result.rect_left   = rect_out_reg.left;
    assign result.rect_top    = rect_out_reg.top;
    assign result.rect_right  = rect_out_reg.right;
    assign result.rect_bottom = rect_out_reg.bottom;

endmodule

// ===== rtl/sfs_checker.sv =====
// Port-level assertions for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg and sprite_frame_sequencer.
module sfs_checker import sfs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [FRAME_W-1:0]    frame_now,
    input logic                  playing,
    input logic [COORD_BITS-1:0] rect_left,
    input logic [COORD_BITS-1:0] rect_top,
    input logic [COORD_BITS-1:0] rect_right,
    input logic [COORD_BITS-1:0] rect_bottom
);

    // One command at a time: a transfer closes the command channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("command taken while a calculation was in progress");

    // A stalled result keeps its valid and payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(frame_now)
            && $stable(playing) && $stable(rect_left) && $stable(rect_top)
            && $stable(rect_right) && $stable(rect_bottom))
        else $error("stalled result changed");

    // Saturation keeps the far edges at or beyond the near edges.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> rect_right >= rect_left && rect_bottom >= rect_top)
        else $error("rectangle edges out of order");

    // The first frame sits at the sheet origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_now == FRAME_W'(1) |-> rect_left == '0 && rect_top == '0)
        else $error("frame one not at the sheet origin");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .frame_now    (result.frame_now),
    .playing      (result.playing),
    .rect_left    (result.rect_left),
    .rect_top     (result.rect_top),
    .rect_right   (result.rect_right),
    .rect_bottom  (result.rect_bottom)
);
